### hdl/fpr_pkg.sv
// Shared constants, types and memory request structs for the FIFO page replacement block.
package fpr_pkg;

	localparam int PAGES   = 64;
	localparam int FRAMES  = 16;
	localparam int PAGE_W  = 6;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;
	localparam int FAULT_W = 16;

	localparam logic [FAULT_W-1:0] FAULT_MAX     = {FAULT_W{1'b1}};
	localparam logic [COUNT_W-1:0] FRAMES_RESET  = COUNT_W'(FRAMES);
	localparam logic [COUNT_W-1:0] FRAMES_COUNT  = COUNT_W'(FRAMES);

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [FAULT_W-1:0] fault_t;

	// page table update on a fault: validate new page, invalidate victim
	typedef struct packed {
		logic  load;
		page_t page;
		slot_t slot;
		logic  evict;
		page_t victim;
	} pt_wr_t;

	// frame store update on a fault
	typedef struct packed {
		logic  load;
		slot_t slot;
		page_t page;
	} fs_wr_t;

endpackage

### hdl/fpr_page_table.sv
// Page table: valid bit per page in flops, frame number per page in a synchronous memory.
module fpr_page_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  fpr_pkg::page_t rd_page,
	output logic           rd_valid,
	output fpr_pkg::slot_t rd_frame,
	input  fpr_pkg::pt_wr_t wr
);

	logic [fpr_pkg::PAGES-1:0] valid_q;
	logic [fpr_pkg::PAGES-1:0] valid_next;
	fpr_pkg::slot_t            frame_mem [fpr_pkg::PAGES];
	logic                      rd_valid_q;
	fpr_pkg::slot_t            rd_frame_q;

	// victim is always a different page, so order does not matter
	always_comb begin
		valid_next = valid_q;
		if (wr.load) begin
			if (wr.evict) begin
				valid_next[wr.victim] = 1'b0;
			end
			valid_next[wr.page] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_page];
			end
			valid_q <= valid_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_frame_q <= frame_mem[rd_page];
		end
		if (wr.load) begin
			frame_mem[wr.page] <= wr.slot;
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_frame = rd_frame_q;

endmodule

### hdl/fpr_frame_store.sv
// Frame store: page held by each frame in a synchronous memory, full bit per frame in flops.
module fpr_frame_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  fpr_pkg::slot_t rd_slot,
	output logic           rd_full,
	output fpr_pkg::page_t rd_page,
	input  fpr_pkg::fs_wr_t wr
);

	logic [fpr_pkg::FRAMES-1:0] full_q;
	fpr_pkg::page_t             page_mem [fpr_pkg::FRAMES];
	logic                       rd_full_q;
	fpr_pkg::page_t             rd_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= '0;
			rd_full_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_full_q <= full_q[rd_slot];
			end
			if (wr.load) begin
				full_q[wr.slot] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_page_q <= page_mem[rd_slot];
		end
		if (wr.load) begin
			page_mem[wr.slot] <= wr.page;
		end
	end

	assign rd_full = rd_full_q;
	assign rd_page = rd_page_q;

endmodule

### hdl/fifo_page_replacement.sv
// A result is registered when its lookup fires in S_LOOK, after the request is accepted;
// a new request is taken only in S_IDLE. The page table and frame store are read at
// acceptance and written back when the lookup fires, before the next request may read.
// A waiting result does not block the next request until its own write-back cycle.
// Reset: asynchronous; valid and full bits, pointer and fault count clear at once,
// no clearing pass; frames_q returns to 16.
module fifo_page_replacement (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic [4:0]               cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [5:0]               page,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic [3:0]               frame_slot,
	output logic                     evicted_valid,
	output logic [5:0]               evicted_page,
	output logic [15:0]              fault_count
);

	typedef enum logic {S_IDLE, S_LOOK} state_t;

	state_t            state_q;
	fpr_pkg::count_t   frames_q;
	fpr_pkg::slot_t    ptr_q;
	fpr_pkg::fault_t   faults_q;
	fpr_pkg::page_t    page_s1;
	fpr_pkg::slot_t    slot_s1;

	logic              out_valid_q;
	logic              hit_q;
	fpr_pkg::slot_t    slot_q;
	logic              ev_valid_q;
	fpr_pkg::page_t    ev_page_q;

	logic              accept;
	logic              fire;
	fpr_pkg::count_t   active_n;
	fpr_pkg::slot_t    slot_a;
	fpr_pkg::count_t   slot_inc;
	fpr_pkg::slot_t    ptr_next;
	fpr_pkg::fault_t   faults_next;
	logic              fault;
	logic              pt_valid;
	fpr_pkg::slot_t    pt_frame;
	logic              fs_full;
	fpr_pkg::page_t    fs_page;
	fpr_pkg::pt_wr_t   pt_wr;
	fpr_pkg::fs_wr_t   fs_wr;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign fire     = (state_q == S_LOOK) && (!out_valid_q || !out_stall);

	// effective frame count: 0 acts as 1, above FRAMES acts as FRAMES
	always_comb begin
		if (frames_q == '0) begin
			active_n = fpr_pkg::count_t'(1);
		end else if (frames_q > fpr_pkg::FRAMES_COUNT) begin
			active_n = fpr_pkg::FRAMES_COUNT;
		end else begin
			active_n = frames_q;
		end
	end

	assign slot_a      = ({1'b0, ptr_q} >= active_n) ? '0 : ptr_q;
	assign slot_inc    = {1'b0, slot_s1} + fpr_pkg::count_t'(1);
	assign ptr_next    = (slot_inc == active_n) ? '0 : slot_inc[fpr_pkg::SLOT_W-1:0];
	assign fault       = !pt_valid;
	assign faults_next = (faults_q != fpr_pkg::FAULT_MAX) ?
		faults_q + fpr_pkg::fault_t'(1) : faults_q;

	always_comb begin
		pt_wr.load   = fire && fault;
		pt_wr.page   = page_s1;
		pt_wr.slot   = slot_s1;
		pt_wr.evict  = fs_full;
		pt_wr.victim = fs_page;
		fs_wr.load   = fire && fault;
		fs_wr.slot   = slot_s1;
		fs_wr.page   = page_s1;
	end

	fpr_page_table u_page_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_page  (page),
		.rd_valid (pt_valid),
		.rd_frame (pt_frame),
		.wr       (pt_wr)
	);

	fpr_frame_store u_frame_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_slot (slot_a),
		.rd_full (fs_full),
		.rd_page (fs_page),
		.wr      (fs_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frames_q    <= fpr_pkg::FRAMES_RESET;
			ptr_q       <= '0;
			faults_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				frames_q <= cfg_wdata;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (fire) begin
						state_q <= S_IDLE;
						if (fault) begin
							ptr_q    <= ptr_next;
							faults_q <= faults_next;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= page;
			slot_s1 <= slot_a;
		end
		if (fire) begin
			hit_q      <= pt_valid;
			slot_q     <= pt_valid ? pt_frame : slot_s1;
			ev_valid_q <= fault && fs_full;
			ev_page_q  <= (fault && fs_full) ? fs_page : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = faults_q;

	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_LOOK))
		else $error("result raised without a lookup cycle");

	a_faults_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		faults_q >= $past(faults_q))
		else $error("fault count decreased");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && ev_valid_q))
		else $error("eviction reported on a hit");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fault |=> ({1'b0, ptr_q} < active_n))
		else $error("replacement pointer outside active frames");

endmodule
